/* hdl/fftr_pkg.sv */
`default_nettype none
package fftr_pkg;
    localparam int USERS      = 16;
    localparam int FEED_LEN   = 10;
    localparam int STAMP_BITS = 32;
    localparam int UW   = $clog2(USERS);
    localparam int SW   = $clog2(FEED_LEN + 1);
    localparam int PW   = (FEED_LEN > 1) ? $clog2(FEED_LEN) : 1;
    localparam int DEPTH = USERS * FEED_LEN;
    localparam int AW   = $clog2(DEPTH);
    localparam int IDW  = 31;

    localparam logic [1:0] OP_POST     = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_FOLLOW   = 2'd2;
    localparam logic [1:0] OP_UNFOLLOW = 2'd3;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef struct packed {
        logic             found;
        logic [IDW-1:0]   id;
    } pick_t;
endpackage
`default_nettype wire

/* hdl/fftr_max.sv */
`default_nettype none
// Shared compare unit: running maximum of stamps, below a bound when bounded is set.
module fftr_max (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             en,
    input  wire logic [fftr_pkg::STAMP_BITS-1:0] stamp,
    input  wire logic [fftr_pkg::IDW-1:0]        id,
    input  wire logic                             bounded,
    input  wire logic [fftr_pkg::STAMP_BITS-1:0] bound,
    output fftr_pkg::pick_t                       pick,
    output logic [fftr_pkg::STAMP_BITS-1:0]      best
);
    logic                             found_reg;
    logic [fftr_pkg::STAMP_BITS-1:0] best_reg;
    logic [fftr_pkg::IDW-1:0]        id_reg;
    logic                             take;

    assign take = en && !(bounded && stamp >= bound) && (!found_reg || stamp > best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !clear)
        begin
            best_reg <= stamp;
            id_reg   <= id;
        end
    end

    assign pick.found = found_reg;
    assign pick.id    = id_reg;
    assign best       = best_reg;
endmodule
`default_nettype wire

/* hdl/follow_feed_top_recent_top.sv */
`default_nettype none
// Post, follow, unfollow: busy in S_DONE after the transfer, so no new request is taken until idle.
// Feed query: rounds of S_SCAN, S_TAIL and S_EMIT (one-entry-per-cycle scan of the post
// memory through one shared compare unit), one round per result plus one that finds
// nothing, at most FEED_LEN rounds, with S_LAST in place of the empty round when the
// feed is full.
// Results are strobed by result_valid for one cycle; reset is asynchronous, active low.
module follow_feed_top_recent_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  user_id,
    input  wire logic [30:0] post_id,
    input  wire logic [3:0]  other_user,
    output logic             result_valid,
    output logic [30:0]      feed_post_id,
    output logic             feed_empty,
    output logic             last_of_feed,
    output logic             stamp_exhausted
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // address phase runs a cycle ahead
    localparam logic [2:0] S_TAIL = 3'd2;  // last memory read drains
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;  // flush held result of a full feed

    localparam int EW = fftr_pkg::STAMP_BITS + fftr_pkg::IDW;

    logic [2:0]                          state_reg, state_next;
    logic [fftr_pkg::UW-1:0]             q_reg;
    logic [fftr_pkg::UW-1:0]             su_reg;     // scan user
    logic [fftr_pkg::PW-1:0]             si_reg;     // scan slot
    logic [fftr_pkg::SW-1:0]             n_reg;      // results given
    logic                                bounded_reg;
    logic [fftr_pkg::STAMP_BITS-1:0]    bound_reg;
    logic [fftr_pkg::SW-1:0]             cnt_reg [fftr_pkg::USERS];
    logic [fftr_pkg::PW-1:0]             ptr_reg [fftr_pkg::USERS];
    logic [fftr_pkg::USERS-1:0]          fol_reg [fftr_pkg::USERS];
    logic [fftr_pkg::STAMP_BITS-1:0]    stamp_reg;
    logic                                ovf_reg;
    logic [fftr_pkg::IDW-1:0]            hold_reg;   // result waiting for its last flag

    // post memory
    logic [EW-1:0]                       mem [fftr_pkg::DEPTH];
    logic [EW-1:0]                       rd_reg;
    logic                                rdv_reg;    // read is a valid candidate

    logic                                cand;
    logic [fftr_pkg::AW-1:0]             rd_addr, wr_addr;
    logic                                wr_en;
    logic                                clr;
    fftr_pkg::pick_t                     pick;
    logic [fftr_pkg::STAMP_BITS-1:0]    best;
    logic                                accept;
    logic                                scan_end;
    logic                                emit;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign scan_end = (su_reg == fftr_pkg::UW'(fftr_pkg::USERS - 1))
                   && (si_reg == fftr_pkg::PW'(fftr_pkg::FEED_LEN - 1));

    assign cand = (su_reg == q_reg || fol_reg[q_reg][su_reg])
               && ({1'b0, si_reg} < (fftr_pkg::SW + 1)'(cnt_reg[su_reg]));
    assign rd_addr = fftr_pkg::AW'(su_reg * fftr_pkg::FEED_LEN + si_reg);
    assign wr_addr = fftr_pkg::AW'(user_id * fftr_pkg::FEED_LEN + ptr_reg[user_id]);
    assign wr_en   = accept && opcode == fftr_pkg::OP_POST && stamp_reg != fftr_pkg::STAMP_MAX;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {stamp_reg, post_id};
        end
        rd_reg <= mem[rd_addr];
    end

    assign clr = (state_reg == S_EMIT);

    fftr_max u_max (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clr),
        .en      (rdv_reg),
        .stamp   (rd_reg[EW-1:fftr_pkg::IDW]),
        .id      (rd_reg[fftr_pkg::IDW-1:0]),
        .bounded (bounded_reg),
        .bound   (bound_reg),
        .pick    (pick),
        .best    (best)
    );

    // A found post is held for one round: only the next round tells whether it
    // was the last one. The round that finds nothing releases it flagged last;
    // a full feed releases it in S_LAST.
    assign emit = ((state_reg == S_EMIT) && (!pick.found || n_reg != '0))
               || (state_reg == S_LAST);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept && opcode == fftr_pkg::OP_QUERY) state_next = S_SCAN;
                    else if (accept) state_next = S_DONE;
            S_SCAN: if (scan_end) state_next = S_TAIL;
            S_TAIL: state_next = S_EMIT;
            S_EMIT: if (!pick.found)
                        state_next = S_IDLE;
                    else if (n_reg == fftr_pkg::SW'(fftr_pkg::FEED_LEN - 1))
                        state_next = S_LAST;
                    else
                        state_next = S_SCAN;
            S_DONE: state_next = S_IDLE;
            S_LAST: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            su_reg       <= '0;
            si_reg       <= '0;
            n_reg        <= '0;
            q_reg        <= '0;
            bounded_reg  <= 1'b0;
            bound_reg    <= '0;
            rdv_reg      <= 1'b0;
            stamp_reg    <= '0;
            ovf_reg      <= 1'b0;
            hold_reg     <= '0;
            result_valid <= 1'b0;
            feed_post_id <= '0;
            feed_empty   <= 1'b0;
            last_of_feed <= 1'b0;
            for (int u = 0; u < fftr_pkg::USERS; u++)
            begin
                cnt_reg[u] <= '0;
                ptr_reg[u] <= '0;
                fol_reg[u] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= emit;
            rdv_reg      <= (state_reg == S_SCAN) && cand;
            if (accept)
            begin
                q_reg       <= user_id;
                su_reg      <= '0;
                si_reg      <= '0;
                n_reg       <= '0;
                bounded_reg <= 1'b0;
                case (opcode)
                    fftr_pkg::OP_POST:
                    begin
                        if (stamp_reg == fftr_pkg::STAMP_MAX)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            stamp_reg <= stamp_reg + 1'b1;
                            ptr_reg[user_id] <= (ptr_reg[user_id] ==
                                fftr_pkg::PW'(fftr_pkg::FEED_LEN - 1)) ? '0
                                : ptr_reg[user_id] + 1'b1;
                            if (cnt_reg[user_id] != fftr_pkg::SW'(fftr_pkg::FEED_LEN))
                            begin
                                cnt_reg[user_id] <= cnt_reg[user_id] + 1'b1;
                            end
                        end
                    end
                    fftr_pkg::OP_FOLLOW:
                        if (user_id != other_user) fol_reg[user_id][other_user] <= 1'b1;
                    fftr_pkg::OP_UNFOLLOW:
                        fol_reg[user_id][other_user] <= 1'b0;
                    default: ;
                endcase
            end
            if (state_reg == S_SCAN)
            begin
                if (si_reg == fftr_pkg::PW'(fftr_pkg::FEED_LEN - 1))
                begin
                    si_reg <= '0;
                    su_reg <= su_reg + 1'b1;
                end
                else
                begin
                    si_reg <= si_reg + 1'b1;
                end
            end
            if (state_reg == S_EMIT)
            begin
                bounded_reg <= 1'b1;
                bound_reg   <= best;
                n_reg       <= n_reg + 1'b1;
                su_reg      <= '0;
                si_reg      <= '0;
                if (pick.found)
                begin
                    hold_reg <= pick.id;
                    if (n_reg != '0)
                    begin
                        feed_post_id <= hold_reg;
                        feed_empty   <= 1'b0;
                        last_of_feed <= 1'b0;
                    end
                end
                else if (n_reg == '0)
                begin
                    feed_post_id <= '0;
                    feed_empty   <= 1'b1;
                    last_of_feed <= 1'b1;
                end
                else
                begin
                    feed_post_id <= hold_reg;
                    feed_empty   <= 1'b0;
                    last_of_feed <= 1'b1;
                end
            end
            if (state_reg == S_LAST)
            begin
                feed_post_id <= hold_reg;
                feed_empty   <= 1'b0;
                last_of_feed <= 1'b1;
            end
        end
    end

    assign stamp_exhausted = ovf_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(state_reg) == S_EMIT || $past(state_reg) == S_LAST)
        else $error("result outside query");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && feed_empty |-> feed_post_id == '0 && last_of_feed)
        else $error("empty result malformed");
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ovf_reg) |-> ovf_reg)
        else $error("overflow flag dropped");
`endif
endmodule
`default_nettype wire
